/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define SPS_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sps check failed");

// Next-cycle implication, masked during reset
`define SPS_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sps check failed");

// Next-cycle implication, active through reset
`define SPS_ASSERT_RST(label, pre, post) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("sps check failed");

`endif

/* rtl/core/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants, types and state codes of the shortest path search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int MAX_EDGES = 512;
    localparam int EADDR_W   = 9;
    localparam int ETOT_W    = 10;
    localparam int COST_BITS = 16;
    localparam int DIST_W    = COST_BITS + 8;
    localparam int PRED_W    = 7;

    localparam logic [DIST_W-1:0] DIST_INF  = '1;
    localparam logic [PRED_W-1:0] PRED_NONE = '1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [NODE_W-1:0]    src;
        logic [NODE_W-1:0]    dst;
        logic [COST_BITS-1:0] cost;
    } t_edge;

    typedef struct packed {
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [DIST_W-1:0] wr_dist;
        logic [PRED_W-1:0] wr_pred;
        logic              clr_all;
        logic              visit_en;
        logic [NODE_W-1:0] visit_addr;
    } t_node_req;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic [PRED_W-1:0] pred;
        logic              live;
        logic              visited;
    } t_node_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_END,
        ST_R_EDGE,
        ST_R_CHK,
        ST_R_UPD,
        ST_W_RD,
        ST_W_CHK,
        ST_E_RD,
        ST_E_LD,
        ST_E_WAIT,
        ST_FAIL
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/sps_edge_store.sv */
// ----------------------------------------------------------------------------
// sps_edge_store
// Edge memory in load order with its fill count; one write, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_edge_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  logic                         i_add,
    input  sps_pkg::t_edge               i_edge,
    input  logic [sps_pkg::EADDR_W-1:0]  i_rd_addr,
    output sps_pkg::t_edge               o_rd_edge,
    output logic [sps_pkg::ETOT_W-1:0]   o_total
);
    import sps_pkg::*;

    t_edge               r_mem [MAX_EDGES];
    t_edge               r_rd;
    logic [ETOT_W-1:0]   r_total;
    logic [ETOT_W-1:0]   n_total;
    logic                w_room;

    assign w_room = (r_total < ETOT_W'(MAX_EDGES));

    // Advance or drop the fill count
    always_comb begin
        n_total = r_total;
        if (i_clr) begin
            n_total = '0;
        end else if (i_add && w_room) begin
            n_total = r_total + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // Append at the fill count, read at the requested entry
    always_ff @(posedge i_clk) begin
        if (i_add && !i_clr && w_room) begin
            r_mem[r_total[EADDR_W-1:0]] <= i_edge;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_edge = r_rd;
    assign o_total   = r_total;

endmodule

`default_nettype wire

/* rtl/core/sps_node_table.sv */
// ----------------------------------------------------------------------------
// sps_node_table
// Per-node distance and predecessor memory with per-query live and visited bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_node_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sps_pkg::t_node_req i_req,
    output sps_pkg::t_node_rsp o_rsp
);
    import sps_pkg::*;

    logic [DIST_W-1:0]    r_dist [MAX_NODES];
    logic [PRED_W-1:0]    r_pred [MAX_NODES];
    logic [MAX_NODES-1:0] r_live;
    logic [MAX_NODES-1:0] r_visit;
    logic [MAX_NODES-1:0] n_live;
    logic [MAX_NODES-1:0] n_visit;
    t_node_rsp            r_rsp;

    // Drop all marks at query start, then set on write or visit
    always_comb begin
        n_live  = i_req.clr_all ? '0 : r_live;
        n_visit = i_req.clr_all ? '0 : r_visit;
        if (i_req.wr_en) begin
            n_live[i_req.wr_addr] = 1'b1;
        end
        if (i_req.visit_en) begin
            n_visit[i_req.visit_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= '0;
            r_visit <= '0;
        end else begin
            r_live  <= n_live;
            r_visit <= n_visit;
        end
    end

    // Memory write and registered read; an entry not live reads as infinity
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_dist[i_req.wr_addr] <= i_req.wr_dist;
            r_pred[i_req.wr_addr] <= i_req.wr_pred;
        end
        r_rsp.dist_val <= r_live[i_req.rd_addr] ? r_dist[i_req.rd_addr] : DIST_INF;
        r_rsp.pred     <= r_live[i_req.rd_addr] ? r_pred[i_req.rd_addr] : PRED_NONE;
        r_rsp.live     <= r_live[i_req.rd_addr];
        r_rsp.visited  <= r_visit[i_req.rd_addr];
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

/* rtl/core/sps_ctrl.sv */
// ----------------------------------------------------------------------------
// sps_ctrl
// Search sequencer: minimum scan, edge relaxation, path walk and beat output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_query,
    input  logic [sps_pkg::NODE_W-1:0]   i_start,
    input  logic [sps_pkg::NODE_W-1:0]   i_goal,
    input  logic [sps_pkg::CNT_W-1:0]    i_n,
    output logic                         o_busy,
    output logic [sps_pkg::EADDR_W-1:0]  o_edge_addr,
    input  sps_pkg::t_edge               i_edge,
    input  logic [sps_pkg::ETOT_W-1:0]   i_edge_total,
    output sps_pkg::t_node_req           o_node_req,
    input  sps_pkg::t_node_rsp           i_node_rsp,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sps_pkg::NODE_W-1:0]   o_path_node,
    output logic                         o_path_found,
    output logic                         o_last
);
    import sps_pkg::*;

    t_state               r_state, n_state;
    logic [NODE_W-1:0]    r_start, n_start;
    logic [NODE_W-1:0]    r_goal, n_goal;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_have, n_have;
    logic [NODE_W-1:0]    r_u, n_u;
    logic [DIST_W-1:0]    r_du, n_du;
    logic [ETOT_W-1:0]    r_e, n_e;
    logic [NODE_W-1:0]    r_edst, n_edst;
    logic [COST_BITS-1:0] r_ecost, n_ecost;
    logic [NODE_W-1:0]    r_v, n_v;
    logic [CNT_W-1:0]     r_len, n_len;
    logic [CNT_W-1:0]     r_i, n_i;
    logic                 r_out_valid, n_out_valid;
    logic [NODE_W-1:0]    r_out_node, n_out_node;
    logic                 r_out_found, n_out_found;
    logic                 r_out_last, n_out_last;

    logic [NODE_W-1:0]    r_pbuf [MAX_NODES];
    logic [NODE_W-1:0]    r_pbuf_rd;
    logic                 w_pbuf_we;
    logic [NODE_W-1:0]    w_pbuf_raddr;
    logic [CNT_W-1:0]     w_pbuf_ridx;

    logic [DIST_W:0]      w_sum;
    logic [DIST_W-1:0]    w_nd;
    logic [PRED_W-1:0]    w_pred;
    t_node_req            w_req;

    // Saturating distance sum for relaxation
    assign w_sum  = {1'b0, r_du} + (DIST_W+1)'(r_ecost);
    assign w_nd   = (w_sum >= {1'b0, DIST_INF}) ? (DIST_INF - 1'b1) : w_sum[DIST_W-1:0];
    assign w_pred = i_node_rsp.pred;

    assign w_pbuf_ridx  = r_len - 1'b1 - r_i;
    assign w_pbuf_raddr = w_pbuf_ridx[NODE_W-1:0];
    assign o_edge_addr  = r_e[EADDR_W-1:0];

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_goal      = r_goal;
        n_n         = r_n;
        n_idx       = r_idx;
        n_have      = r_have;
        n_u         = r_u;
        n_du        = r_du;
        n_e         = r_e;
        n_edst      = r_edst;
        n_ecost     = r_ecost;
        n_v         = r_v;
        n_len       = r_len;
        n_i         = r_i;
        n_out_valid = r_out_valid;
        n_out_node  = r_out_node;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        w_pbuf_we   = 1'b0;
        w_req       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_query) begin
                    n_start = i_start;
                    n_goal  = i_goal;
                    n_n     = i_n;
                    if (i_n == '0 || {1'b0, i_start} >= i_n || {1'b0, i_goal} >= i_n) begin
                        n_state = ST_FAIL;
                    end else begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                w_req.clr_all = 1'b1;
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_start;
                w_req.wr_dist = '0;
                w_req.wr_pred = PRED_NONE;
                n_idx         = '0;
                n_have        = 1'b0;
                n_state       = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                w_req.rd_addr = r_idx[NODE_W-1:0];
                n_state       = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                // Keep the lowest id on ties: replace only on strictly smaller
                if (i_node_rsp.live && !i_node_rsp.visited &&
                    (!r_have || i_node_rsp.dist_val < r_du)) begin
                    n_have = 1'b1;
                    n_u    = r_idx[NODE_W-1:0];
                    n_du   = i_node_rsp.dist_val;
                end
                n_idx   = r_idx + 1'b1;
                n_state = (r_idx + 1'b1 >= r_n) ? ST_SCAN_END : ST_SCAN_RD;
            end
            ST_SCAN_END: begin
                if (!r_have) begin
                    n_state = ST_FAIL;
                end else begin
                    w_req.visit_en   = 1'b1;
                    w_req.visit_addr = r_u;
                    if (r_u == r_goal) begin
                        n_v     = r_goal;
                        n_len   = '0;
                        n_state = ST_W_RD;
                    end else begin
                        n_e     = '0;
                        n_state = ST_R_EDGE;
                    end
                end
            end
            ST_R_EDGE: begin
                if (r_e >= i_edge_total) begin
                    n_idx   = '0;
                    n_have  = 1'b0;
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                if (i_edge.src == r_u && {1'b0, i_edge.dst} < r_n) begin
                    w_req.rd_addr = i_edge.dst;
                    n_edst        = i_edge.dst;
                    n_ecost       = i_edge.cost;
                    n_state       = ST_R_UPD;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = ST_R_EDGE;
                end
            end
            ST_R_UPD: begin
                if (w_nd < i_node_rsp.dist_val) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_edst;
                    w_req.wr_dist = w_nd;
                    w_req.wr_pred = PRED_W'(r_u);
                end
                n_e     = r_e + 1'b1;
                n_state = ST_R_EDGE;
            end
            ST_W_RD: begin
                w_req.rd_addr = r_v;
                n_state       = ST_W_CHK;
            end
            ST_W_CHK: begin
                // Store the node, then follow its predecessor back
                w_pbuf_we = 1'b1;
                n_len     = r_len + 1'b1;
                if (w_pred == PRED_NONE || w_pred >= PRED_W'(r_n) || r_len + 1'b1 >= r_n) begin
                    n_i     = '0;
                    n_state = ST_E_RD;
                end else begin
                    n_v     = w_pred[NODE_W-1:0];
                    n_state = ST_W_RD;
                end
            end
            ST_E_RD: begin
                n_state = ST_E_LD;
            end
            ST_E_LD: begin
                n_out_valid = 1'b1;
                n_out_node  = r_pbuf_rd;
                n_out_found = 1'b1;
                n_out_last  = (r_i + 1'b1 == r_len);
                n_state     = ST_E_WAIT;
            end
            ST_E_WAIT: begin
                if (r_out_valid && !i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_E_RD;
                    end
                end
            end
            ST_FAIL: begin
                n_out_valid = 1'b1;
                n_out_node  = '0;
                n_out_found = 1'b0;
                n_out_last  = 1'b1;
                n_state     = ST_E_WAIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_goal      <= n_goal;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_have      <= n_have;
        r_u         <= n_u;
        r_du        <= n_du;
        r_e         <= n_e;
        r_edst      <= n_edst;
        r_ecost     <= n_ecost;
        r_v         <= n_v;
        r_len       <= n_len;
        r_i         <= n_i;
        r_out_node  <= n_out_node;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    // Path buffer memory
    always_ff @(posedge i_clk) begin
        if (w_pbuf_we) begin
            r_pbuf[r_len[NODE_W-1:0]] <= r_v;
        end
        r_pbuf_rd <= r_pbuf[w_pbuf_raddr];
    end

    assign o_node_req   = w_req;
    assign o_busy       = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_path_node  = r_out_node;
    assign o_path_found = r_out_found;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

/* rtl/core/shortest_path_search.sv */
// Clear and add-edge items: accepted one per cycle while no query is running, no result.
// Query: a minimum scan of the nodes in use and a pass over all stored edges for
// each visited node, then a walk back over the path nodes, then the result beats.
// One query at a time; the input stalls until its last beat is taken.
// Reset (synchronous): edge count, node_count and sequencer clear; no clearing pass.
// ----------------------------------------------------------------------------
// shortest_path_search
// Dijkstra single-pair search over a loaded edge list, path emitted node by node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shortest_path_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic [sps_pkg::NODE_W-1:0]   i_src_node,
    input  logic [sps_pkg::NODE_W-1:0]   i_dst_node,
    input  logic [15:0]                  i_edge_cost,
    input  logic [sps_pkg::NODE_W-1:0]   i_start_node,
    input  logic [sps_pkg::NODE_W-1:0]   i_goal_node,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sps_pkg::NODE_W-1:0]   o_path_node,
    output logic                         o_path_found,
    output logic                         o_last
);
    import sps_pkg::*;

    localparam logic REG_NODE_COUNT = 1'b0;

    logic [CNT_W-1:0]   r_node_count;
    logic [CNT_W-1:0]   w_n;
    logic               w_acc;
    logic               w_busy;
    t_op                w_op;
    t_edge              w_edge_in;
    t_edge              w_edge_rd;
    logic [EADDR_W-1:0] w_edge_addr;
    logic [ETOT_W-1:0]  w_edge_total;
    t_node_req          w_node_req;
    t_node_rsp          w_node_rsp;

    // Register write on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(r_node_count) : '0;

    // Limit nodes in use to the table depth
    assign w_n = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;

    assign o_stall   = w_busy;
    assign w_acc     = i_valid && !w_busy;
    assign w_op      = t_op'(i_op);
    assign w_edge_in = '{src: i_src_node, dst: i_dst_node, cost: i_edge_cost[COST_BITS-1:0]};

    sps_edge_store u_edges (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_acc && w_op == OP_CLEAR),
        .i_add     (w_acc && w_op == OP_ADD),
        .i_edge    (w_edge_in),
        .i_rd_addr (w_edge_addr),
        .o_rd_edge (w_edge_rd),
        .o_total   (w_edge_total)
    );

    sps_node_table u_nodes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_node_req),
        .o_rsp   (w_node_rsp)
    );

    sps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_query      (w_acc && w_op == OP_QUERY),
        .i_start      (i_start_node),
        .i_goal       (i_goal_node),
        .i_n          (w_n),
        .o_busy       (w_busy),
        .o_edge_addr  (w_edge_addr),
        .i_edge       (w_edge_rd),
        .i_edge_total (w_edge_total),
        .o_node_req   (w_node_req),
        .i_node_rsp   (w_node_rsp),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_path_node  (o_path_node),
        .o_path_found (o_path_found),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

/* rtl/core/sps_checker.sv */
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks of the shortest path search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sps_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [5:0]  o_path_node,
    input  logic        o_path_found,
    input  logic        o_last
);

    // A stalled result beat holds
    `SPS_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable({o_path_node, o_last}))

    // A not-found beat ends its query
    `SPS_ASSERT_IMP(a_fail_last, o_valid && !o_path_found, o_last)

    // Results appear only while a query holds the input
    `SPS_ASSERT_IMP(a_out_busy, o_valid, o_stall)

    // Reset empties the output
    `SPS_ASSERT_RST(a_rst_empty, !i_rst_n, !o_valid && !o_stall)

endmodule

bind shortest_path_search sps_checker u_sps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_path_node  (o_path_node),
    .o_path_found (o_path_found),
    .o_last       (o_last)
);

`default_nettype wire

/* verif/sps_route_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_route_checker
// Watches the edge/query beats, the register port and the path beats of the
// shortest path search block, keeps its own graph and computes the expected
// path of every query, then compares each path beat against it.
// ----------------------------------------------------------------------------

module sps_route_checker
    import sps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              i_valid,
    input  logic              i_stall_in,
    input  logic [1:0]        i_op,
    input  logic [NODE_W-1:0] i_src_node,
    input  logic [NODE_W-1:0] i_dst_node,
    input  logic [15:0]       i_edge_cost,
    input  logic [NODE_W-1:0] i_start_node,
    input  logic [NODE_W-1:0] i_goal_node,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [NODE_W-1:0] i_path_node,
    input  logic              i_path_found,
    input  logic              i_last,
    output int                o_errors,
    output int                o_pending,
    output int                o_beats
);

    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              found;
        logic              last;
    } t_hop;

    t_edge          graph_edges [MAX_EDGES];
    int unsigned    graph_size;
    logic [CNT_W-1:0] node_count;
    t_hop           path_queue [$];

    logic [DIST_W-1:0] dist_tab [MAX_NODES];
    logic [PRED_W-1:0] pred_tab [MAX_NODES];
    logic              done_tab [MAX_NODES];

    assign o_pending = path_queue.size();

    // Run the search on the local graph copy and queue the path beats
    function automatic void predict_route(input int unsigned start, input int unsigned goal);
        int unsigned n;
        int unsigned u;
        int unsigned v;
        int unsigned len;
        logic [DIST_W:0] sum;
        int unsigned chain [MAX_NODES];
        t_hop hop;
        n = (node_count > MAX_NODES) ? MAX_NODES : node_count;
        if (n == 0 || start >= n || goal >= n) begin
            hop = '{node: '0, found: 1'b0, last: 1'b1};
            path_queue.insert(path_queue.size(), hop);
            return;
        end
        for (int i = 0; i < n; i++) begin
            dist_tab[i] = DIST_INF;
            pred_tab[i] = PRED_NONE;
            done_tab[i] = 1'b0;
        end
        dist_tab[start] = '0;
        forever begin
            u = n;
            for (int i = 0; i < n; i++) begin
                if (!done_tab[i] && dist_tab[i] != DIST_INF &&
                    (u == n || dist_tab[i] < dist_tab[u]))
                    u = i;
            end
            if (u == n) break;
            done_tab[u] = 1'b1;
            if (u == goal) break;
            // relax outgoing edges in load order, strict less-than
            for (int e = 0; e < graph_size; e++) begin
                if (graph_edges[e].src != u || graph_edges[e].dst >= n) continue;
                sum = {1'b0, dist_tab[u]} + graph_edges[e].cost;
                if (sum >= {1'b0, DIST_INF}) sum = {1'b0, DIST_INF} - 1'b1;
                if (sum[DIST_W-1:0] < dist_tab[graph_edges[e].dst]) begin
                    dist_tab[graph_edges[e].dst] = sum[DIST_W-1:0];
                    pred_tab[graph_edges[e].dst] = PRED_W'(u);
                end
            end
        end
        if (dist_tab[goal] == DIST_INF) begin
            hop = '{node: '0, found: 1'b0, last: 1'b1};
            path_queue.insert(path_queue.size(), hop);
            return;
        end
        // walk predecessors back from the goal
        len = 0;
        v = goal;
        while (len < n) begin
            chain[len] = v;
            len++;
            if (pred_tab[v] == PRED_NONE || pred_tab[v] >= n) break;
            v = pred_tab[v];
        end
        for (int i = 0; i < len; i++) begin
            hop.node  = NODE_W'(chain[len-1-i]);
            hop.found = 1'b1;
            hop.last  = (i + 1 == len);
            path_queue.insert(path_queue.size(), hop);
        end
    endfunction

    always @(posedge i_clk) begin
        t_hop want;
        if (!i_rst_n) begin
            graph_size = 0;
            node_count = '0;
            o_errors   = 0;
            o_beats    = 0;
            path_queue.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready && paddr == ADDR_NODE_COUNT)
                node_count = pwdata[CNT_W-1:0];
            // consume an input beat
            if (i_valid && !i_stall_in) begin
                case (t_op'(i_op))
                    OP_CLEAR: graph_size = 0;
                    OP_ADD: begin
                        if (graph_size < MAX_EDGES) begin
                            graph_edges[graph_size] = '{src: i_src_node, dst: i_dst_node,
                                                        cost: i_edge_cost};
                            graph_size++;
                        end
                    end
                    OP_QUERY: predict_route(i_start_node, i_goal_node);
                    default: ;
                endcase
            end
            // compare a path beat
            if (i_out_valid && !i_out_stall) begin
                o_beats++;
                if (path_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: unexpected path beat node=%0d found=%0b last=%0b",
                                 $realtime, i_path_node, i_path_found, i_last);
                end else begin
                    want = path_queue.pop_front();
                    if (want.node !== i_path_node || want.found !== i_path_found ||
                        want.last !== i_last) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"%0t: path beat mismatch exp node=%0d found=%0b ",
                                      "last=%0b, got node=%0d found=%0b last=%0b"},
                                     $realtime, want.node, want.found, want.last,
                                     i_path_node, i_path_found, i_last);
                    end
                end
            end
        end
    end

endmodule

/* verif/tb_shortest_path_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_path_search
// Drives edge loads, clears and queries with random gaps and output stalls,
// sweeps node_count across its range, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_shortest_path_search;
    import sps_pkg::*;

    localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_op = OP_NONE;
    logic [NODE_W-1:0] i_src_node = '0;
    logic [NODE_W-1:0] i_dst_node = '0;
    logic [15:0]       i_edge_cost = '0;
    logic [NODE_W-1:0] i_start_node = '0;
    logic [NODE_W-1:0] i_goal_node = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [NODE_W-1:0] o_path_node;
    logic              o_path_found;
    logic              o_last;

    int errors;
    int pending;
    int beats;
    int beats_sent;
    int queries_sent;
    int settings_used;
    bit calm;
    int stall_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    shortest_path_search dut (.*);

    sps_route_checker u_route_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .i_valid, .i_stall_in(o_stall), .i_op, .i_src_node, .i_dst_node, .i_edge_cost,
        .i_start_node, .i_goal_node, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_path_node(o_path_node), .i_path_found(o_path_found), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_beats(beats)
    );

    // Stall the path output at random after each taken beat, never while calm
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            stall_left = calm ? 0 : $urandom_range(0, 5);
            if (stall_left > 0) i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) i_stall <= 1'b0;
        end
    end

    // Send one beat; valid stays high across back-to-back beats
    task automatic send_beat(input t_op op, input logic [5:0] a, input logic [5:0] b,
                             input logic [15:0] cost);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_src_node   <= a;
        i_dst_node   <= b;
        i_start_node <= a;
        i_goal_node  <= b;
        i_edge_cost  <= cost;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        beats_sent++;
        if (op == OP_QUERY) queries_sent++;
    endtask

    // Drain everything, then write node_count through the register port
    task automatic set_nodes(input int value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NODE_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    function automatic logic [15:0] pick_cost();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3));
            1: return 16'(16'hFFFF - $urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] pick_node(input int n);
        if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom);
        return 6'($urandom_range(0, n - 1));
    endfunction

    initial begin
        int sweep [10] = '{1, 2, 5, 8, 16, 33, 64, 127, 0, 3};
        int n;
        int edge_num;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: node_count zero fails, then a small graph with ties
        send_beat(OP_QUERY, 6'd0, 6'd0, 16'd0);
        set_nodes(4);
        send_beat(OP_ADD, 6'd0, 6'd1, 16'h0000);
        send_beat(OP_ADD, 6'd1, 6'd2, 16'hFFFF);
        send_beat(OP_ADD, 6'd0, 6'd2, 16'hFFFF);
        send_beat(OP_ADD, 6'd2, 6'd40, 16'd1);
        send_beat(OP_ADD, 6'd63, 6'd63, 16'hFFFF);
        send_beat(OP_NONE, 6'd63, 6'd63, 16'hFFFF);
        send_beat(OP_QUERY, 6'd0, 6'd2, 16'd0);
        send_beat(OP_QUERY, 6'd2, 6'd2, 16'd0);
        send_beat(OP_QUERY, 6'd0, 6'd3, 16'd0);
        send_beat(OP_QUERY, 6'd4, 6'd1, 16'd0);
        send_beat(OP_QUERY, 6'd0, 6'd63, 16'd0);
        send_beat(OP_CLEAR, 6'd0, 6'd0, 16'd0);
        send_beat(OP_QUERY, 6'd0, 6'd2, 16'd0);
        set_nodes(64);
        send_beat(OP_ADD, 6'd0, 6'd63, 16'd7);
        send_beat(OP_ADD, 6'd63, 6'd62, 16'd7);
        send_beat(OP_QUERY, 6'd0, 6'd62, 16'd0);
        send_beat(OP_QUERY, 6'd63, 6'd63, 16'd0);

        // Random: sweep node_count, load a graph, then query it
        foreach (sweep[s]) begin
            n = sweep[s];
            set_nodes(n);
            calm = ($urandom_range(0, 3) == 0);
            send_beat(OP_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom));
            edge_num = (n < 2) ? 3 : $urandom_range(4, 12);
            for (int i = 0; i < edge_num; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_beat($urandom_range(0, 1) ? OP_NONE : OP_CLEAR,
                              6'($urandom), 6'($urandom), 16'($urandom));
                else
                    send_beat(OP_ADD, pick_node(n), pick_node(n), pick_cost());
            end
            for (int i = 0; i < 8; i++) begin
                if ($urandom_range(0, 2) == 0)
                    send_beat(OP_ADD, pick_node(n), pick_node(n), pick_cost());
                send_beat(OP_QUERY, pick_node(n), pick_node(n), 16'($urandom));
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d beats including %0d queries over %0d node_count settings;",
                 beats_sent, queries_sent, settings_used);
        $display("checked %0d path beats, %0d mismatches.", beats, errors);
        if (errors == 0 && pending == 0)
            $display("tb_shortest_path_search passed");
        else
            $display("tb_shortest_path_search failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("tb_shortest_path_search failed");
        $finish;
    end

endmodule
